// ----- rtl/ecvp_pkg.sv -----
// shared constants and codes for the enhanced clock victim picker
package ecvp_pkg;

    localparam int FRAMES_DEF   = 32;
    localparam int FRAME_W      = 5;
    localparam int OP_W         = 2;

    localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAN  = 2'd1;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd2;

    localparam logic MODE_FIFO  = 1'b0;
    localparam logic MODE_CLOCK = 1'b1;
    localparam logic MODE_RESET = MODE_CLOCK;

endpackage

// ----- rtl/enhanced_clock_victim_picker.sv -----
// enhanced second-chance clock victim picker with round-robin fallback
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------
//  s_      | s_op, s_frame, s_is_write               | s_valid / s_ready
//  m_      | m_victim_valid, m_victim_frame,         | m_valid / m_ready
//          | m_victim_dirty                          |
//  cfg_    | cfg_wdata (policy_mode)                 | cfg_we, no wait
//
// access, clean, unused ops and round-robin picks are written straight to the
// output register when it is free, else they wait in ST_FINISH; a clock-mode
// pick examines one frame at a time with a single shared use/dirty compare,
// then hands the word to the output register from ST_FINISH.
// s_ready is high only while the sequencer idles; a finished word may wait in
// the output register while the next input word is taken.
// aresetn is synchronous and active low: use and dirty bits clear, hand goes
// to frame 0, policy goes to clock mode.
module enhanced_clock_victim_picker
    import ecvp_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [OP_W-1:0]    s_op,
    input  logic [FRAME_W-1:0] s_frame,
    input  logic               s_is_write,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_victim_valid,
    output logic [FRAME_W-1:0] m_victim_frame,
    output logic               m_victim_dirty
);

    // only frames reachable by the 5-bit frame field ever hold a set bit;
    // higher frames always read as unused and clean
    localparam int STORE = (FRAMES < (1 << FRAME_W)) ? FRAMES : (1 << FRAME_W);
    localparam int IDXW  = $clog2(FRAMES);
    localparam int SW    = $clog2(STORE);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(FRAMES - 1);
    localparam logic [IDXW:0]   STORE_LIM = (IDXW+1)'(STORE);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // next frame around the ring
    function automatic logic [IDXW-1:0] wrap_next(input logic [IDXW-1:0] i);
        wrap_next = (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    state_t               state_reg, state_next;
    logic [STORE-1:0]     use_reg, use_next;
    logic [STORE-1:0]     dirty_reg, dirty_next;
    logic [IDXW-1:0]      hand_reg, hand_next;
    logic                 mode_reg, mode_next;

    // scan sequencer
    logic [IDXW-1:0]      pos_reg, pos_next;
    logic [IDXW-1:0]      cnt_reg, cnt_next;
    logic [1:0]           round_reg, round_next;
    logic                 first_dirty_reg, first_dirty_next;

    // staged result, used by scan results and when the output register is still occupied
    logic                 res_valid_reg, res_valid_next;
    logic [FRAME_W-1:0]   res_frame_reg, res_frame_next;
    logic                 res_dirty_reg, res_dirty_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic                 m_vv_reg, m_vv_next;
    logic [FRAME_W-1:0]   m_vf_reg, m_vf_next;
    logic                 m_vd_reg, m_vd_next;

    // single read port over the bit vectors
    logic [IDXW-1:0]      rd_addr;
    logic                 rd_in_range;
    logic                 rd_use;
    logic                 rd_dirty;

    // write side for access and clean ops
    logic                 wr_in_range;
    logic [SW-1:0]        wr_idx;

    logic                 out_free;
    logic                 hit;
    logic                 want_dirty;
    logic                 nv;
    logic [FRAME_W-1:0]   nf;
    logic                 nd;
    logic                 direct_done;

    assign rd_addr     = (state_reg == ST_SCAN) ? pos_reg : hand_reg;
    assign rd_in_range = ({1'b0, rd_addr} < STORE_LIM);
    assign rd_use      = rd_in_range & use_reg[rd_addr[SW-1:0]];
    assign rd_dirty    = rd_in_range & dirty_reg[rd_addr[SW-1:0]];

    assign wr_in_range = ({{(32-FRAME_W){1'b0}}, s_frame} < 32'(FRAMES));
    assign wr_idx      = s_frame[SW-1:0];

    assign out_free    = !m_valid_reg || m_ready;
    // rounds two and four look for dirty frames
    assign want_dirty  = round_reg[0];
    assign hit         = !rd_use && (rd_dirty == want_dirty);

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_victim_valid = m_vv_reg;
    assign m_victim_frame = m_vf_reg;
    assign m_victim_dirty = m_vd_reg;

    always_comb begin
        state_next       = state_reg;
        use_next         = use_reg;
        dirty_next       = dirty_reg;
        hand_next        = hand_reg;
        mode_next        = mode_reg;
        pos_next         = pos_reg;
        cnt_next         = cnt_reg;
        round_next       = round_reg;
        first_dirty_next = first_dirty_reg;
        res_valid_next   = res_valid_reg;
        res_frame_next   = res_frame_reg;
        res_dirty_next   = res_dirty_reg;
        m_valid_next     = m_valid_reg;
        m_vv_next        = m_vv_reg;
        m_vf_next        = m_vf_reg;
        m_vd_next        = m_vd_reg;
        nv               = 1'b0;
        nf               = '0;
        nd               = 1'b0;
        direct_done      = 1'b0;

        // output word leaves
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            mode_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    direct_done = 1'b1;
                    case (s_op)
                        OP_ACCESS: begin
                            if (wr_in_range) begin
                                use_next[wr_idx] = 1'b1;
                                if (s_is_write) begin
                                    dirty_next[wr_idx] = 1'b1;
                                end
                            end
                        end
                        OP_CLEAN: begin
                            if (wr_in_range) begin
                                dirty_next[wr_idx] = 1'b0;
                            end
                        end
                        OP_PICK: begin
                            if (mode_reg == MODE_CLOCK) begin
                                // start round one at the hand
                                direct_done = 1'b0;
                                state_next  = ST_SCAN;
                                pos_next    = hand_reg;
                                cnt_next    = '0;
                                round_next  = 2'd0;
                            end else begin
                                // round robin: the hand is the victim
                                nv        = 1'b1;
                                nf        = FRAME_W'(hand_reg);
                                nd        = rd_dirty;
                                hand_next = wrap_next(hand_reg);
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (direct_done) begin
                        if (out_free) begin
                            m_valid_next = 1'b1;
                            m_vv_next    = nv;
                            m_vf_next    = nf;
                            m_vd_next    = nd;
                        end else begin
                            res_valid_next = nv;
                            res_frame_next = nf;
                            res_dirty_next = nd;
                            state_next     = ST_FINISH;
                        end
                    end
                end
            end

            ST_SCAN: begin
                if (cnt_reg == '0 && round_reg == 2'd0) begin
                    first_dirty_next = rd_dirty;
                end
                pos_next = wrap_next(pos_reg);
                if (hit) begin
                    res_valid_next = 1'b1;
                    res_frame_next = FRAME_W'(pos_reg);
                    res_dirty_next = rd_dirty;
                    hand_next      = wrap_next(pos_reg);
                    state_next     = ST_FINISH;
                end else begin
                    // round two gives passed frames their second chance
                    if (round_reg == 2'd1 && rd_in_range) begin
                        use_next[pos_reg[SW-1:0]] = 1'b0;
                    end
                    if (cnt_reg == LAST_IDX) begin
                        cnt_next = '0;
                        if (round_reg == 2'd3) begin
                            // all rounds spent: fall back to the hand
                            res_valid_next = 1'b1;
                            res_frame_next = FRAME_W'(hand_reg);
                            res_dirty_next = first_dirty_reg;
                            hand_next      = wrap_next(hand_reg);
                            state_next     = ST_FINISH;
                        end else begin
                            round_next = round_reg + 2'd1;
                        end
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_vv_next    = res_valid_reg;
                    m_vf_next    = res_frame_reg;
                    m_vd_next    = res_dirty_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        // payload, no reset needed
        pos_reg         <= pos_next;
        cnt_reg         <= cnt_next;
        round_reg       <= round_next;
        first_dirty_reg <= first_dirty_next;
        res_valid_reg   <= res_valid_next;
        res_frame_reg   <= res_frame_next;
        res_dirty_reg   <= res_dirty_next;
        m_vv_reg        <= m_vv_next;
        m_vf_reg        <= m_vf_next;
        m_vd_reg        <= m_vd_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            use_reg     <= '0;
            dirty_reg   <= '0;
            hand_reg    <= '0;
            mode_reg    <= MODE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            use_reg     <= use_next;
            dirty_reg   <= dirty_next;
            hand_reg    <= hand_next;
            mode_reg    <= mode_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
